>>> hw/rtl/handle_table_with_id_recycling_unit_assert.svh
// Assertion macros shared by the handle table RTL modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef HANDLE_TABLE_WITH_ID_RECYCLING_UNIT_ASSERT_SVH
`define HANDLE_TABLE_WITH_ID_RECYCLING_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define HTIR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define HTIR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/htir_pkg.sv
// Package for the handle table with identifier recycling.
// Holds field widths, command and status codes and the controller/datapath structs.
`default_nettype none

package htir_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int CMD_W     = 3;
  localparam int HANDLE_W  = 6;
  localparam int DIR_W     = 8;
  localparam int COORD_W   = 16;
  localparam int COLOUR_W  = 8;
  localparam int STATUS_W  = 2;
  localparam int LIVE_W    = 6;
  localparam int FIELDS_W  = DIR_W + 2 * COORD_W + COLOUR_W;

  // Command codes carried on the input channel.
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 3'd0,
    CMD_FREE   = 3'd1,
    CMD_LOOKUP = 3'd2,
    CMD_LIST   = 3'd3,
    CMD_CLEAR  = 3'd4
  } htir_cmd_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STS_OK         = 2'd0,
    STS_FULL       = 2'd1,
    STS_NO_ENTRY   = 2'd2,
    STS_LIST_EMPTY = 2'd3
  } htir_status_t;

  // One result transaction.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle_out;
    logic [DIR_W-1:0]    dir_out;
    logic [COORD_W-1:0]  x_out;
    logic [COORD_W-1:0]  y_out;
    logic [COLOUR_W-1:0] colour_out;
    logic [LIVE_W-1:0]   live_count;
    logic                last;
  } htir_result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic exec;
    logic scan_emit;
    logic scan_skip;
    logic scan_empty;
  } htir_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic scan_live;
    logic scan_end;
    logic scan_found;
  } htir_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/htir_if.sv
// Valid/ready channel interfaces for the handle table's command and result streams.
// Depends on htir_pkg for the field widths.
`default_nettype none

interface htir_in_if;
  logic                          valid;
  logic                          ready;
  logic [htir_pkg::CMD_W-1:0]    cmd;
  logic [htir_pkg::HANDLE_W-1:0] handle;
  logic [htir_pkg::DIR_W-1:0]    dir_in;
  logic [htir_pkg::COORD_W-1:0]  x_in;
  logic [htir_pkg::COORD_W-1:0]  y_in;
  logic [htir_pkg::COLOUR_W-1:0] colour_in;

  modport source (output valid, cmd, handle, dir_in, x_in, y_in, colour_in, input ready);
  modport sink   (input valid, cmd, handle, dir_in, x_in, y_in, colour_in, output ready);
endinterface

interface htir_out_if;
  logic                          valid;
  logic                          ready;
  logic [htir_pkg::STATUS_W-1:0] status;
  logic [htir_pkg::HANDLE_W-1:0] handle_out;
  logic [htir_pkg::DIR_W-1:0]    dir_out;
  logic [htir_pkg::COORD_W-1:0]  x_out;
  logic [htir_pkg::COORD_W-1:0]  y_out;
  logic [htir_pkg::COLOUR_W-1:0] colour_out;
  logic [htir_pkg::LIVE_W-1:0]   live_count;
  logic                          last;

  modport source (output valid, status, handle_out, dir_out, x_out, y_out, colour_out,
                  live_count, last, input ready);
  modport sink   (input valid, status, handle_out, dir_out, x_out, y_out, colour_out,
                  live_count, last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/handle_table_with_id_recycling_unit.sv
// Top level of the handle table with identifier recycling.
// Depends on htir_pkg, htir_if, htir_ctrl and htir_dp.
//
// Usage: commands arrive on in_ch (valid/ready), results leave on out_ch
// (valid/ready). A transaction is taken when valid and ready are both high.
// Allocate, free, lookup and clear give one result each: the command and the
// registered reads of the slot memory and free stack are latched when it is
// taken, the result is loaded into the output register from the execute state
// once that register is free, and only then is the next command taken.
// List scans the live bits one slot per cycle from handle 1 up, holding on a
// live handle while the output register is still full, and emits one result
// per live handle with last set on the final one, or one empty-list result.
// Unknown command codes are taken and give no result.
// When the receiver holds ready low, the result stays in the output register
// and the block waits before loading the next one; a new command is still
// taken while the previous result waits. Reset (synchronous, active low)
// empties the table: no live handles, empty free stack, next handle one.
// Slot and stack memories need no clearing pass.
`default_nettype none

module handle_table_with_id_recycling_unit #(
  parameter int SLOTS = htir_pkg::SLOTS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  htir_in_if.sink  in_ch,
  htir_out_if.source out_ch
);

  htir_pkg::htir_ctl_t    ctl;
  htir_pkg::htir_sts_t    sts;
  htir_pkg::htir_result_t out_data;
  logic                   out_valid;

  htir_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  htir_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .in_cmd    (in_ch.cmd),
    .in_handle (in_ch.handle),
    .in_dir    (in_ch.dir_in),
    .in_x      (in_ch.x_in),
    .in_y      (in_ch.y_in),
    .in_colour (in_ch.colour_in),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  // Result channel drive.
  assign out_ch.valid      = out_valid;
  assign out_ch.status     = out_data.status;
  assign out_ch.handle_out = out_data.handle_out;
  assign out_ch.dir_out    = out_data.dir_out;
  assign out_ch.x_out      = out_data.x_out;
  assign out_ch.y_out      = out_data.y_out;
  assign out_ch.colour_out = out_data.colour_out;
  assign out_ch.live_count = out_data.live_count;
  assign out_ch.last       = out_data.last;

endmodule

`default_nettype wire

>>> hw/rtl/htir_dp.sv
// Datapath of the handle table: slot memory, free stack, live bits, counters,
// list scanner and the result register. Depends on htir_pkg and the assertion header.
`default_nettype none

`include "handle_table_with_id_recycling_unit_assert.svh"

module htir_dp #(
  parameter int SLOTS = htir_pkg::SLOTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire htir_pkg::htir_ctl_t           ctl,
  output      htir_pkg::htir_sts_t           sts,
  input  wire logic [htir_pkg::CMD_W-1:0]    in_cmd,
  input  wire logic [htir_pkg::HANDLE_W-1:0] in_handle,
  input  wire logic [htir_pkg::DIR_W-1:0]    in_dir,
  input  wire logic [htir_pkg::COORD_W-1:0]  in_x,
  input  wire logic [htir_pkg::COORD_W-1:0]  in_y,
  input  wire logic [htir_pkg::COLOUR_W-1:0] in_colour,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      htir_pkg::htir_result_t        out_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = IW + 1;
  localparam int HW = htir_pkg::HANDLE_W;
  localparam logic [CW-1:0] SLOTS_C  = CW'(SLOTS);
  localparam logic [HW:0]   SLOTS_H  = (HW + 1)'(SLOTS);

  // Storage: slot fields and the free stack have no reset.
  logic [htir_pkg::FIELDS_W-1:0] fields_mem [SLOTS];
  logic [HW-1:0]                 stack_mem  [SLOTS];

  // Latched command transaction and registered memory reads.
  logic [htir_pkg::CMD_W-1:0]    cmd_r;
  logic [HW-1:0]                 handle_r;
  logic [htir_pkg::FIELDS_W-1:0] fields_r;
  logic [htir_pkg::FIELDS_W-1:0] fields_q_r;
  logic [HW-1:0]                 stack_q_r;

  // Table state.
  logic [SLOTS-1:0]              live_r, live_nxt;
  logic [CW-1:0]                 free_depth_r, free_depth_nxt;
  logic [CW-1:0]                 next_fresh_r, next_fresh_nxt;
  logic [htir_pkg::LIVE_W-1:0]   live_total_r, live_total_nxt;
  logic [CW-1:0]                 scan_idx_r, scan_idx_nxt;
  logic                          found_r, found_nxt;

  // Result register.
  logic                          out_valid_r;
  htir_pkg::htir_result_t        out_q_r;

  logic                          load;
  htir_pkg::htir_result_t        res;
  logic                          alloc_we;
  logic [IW-1:0]                 alloc_idx;
  logic                          stack_we;
  logic                          handle_ok;
  logic [CW-1:0]                 depth_m1;
  logic [SLOTS-1:0]              above;
  logic                          above_any;

  assign depth_m1 = free_depth_r - CW'(1);

  // A handle is usable when it is nonzero, in range and live.
  assign handle_ok = (handle_r != '0) && ({1'b0, handle_r} < SLOTS_H) &&
                     live_r[handle_r[IW-1:0]];

  // Live handles above the scan position decide the last flag of a listed handle.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      above[i] = live_r[i] && (CW'(i) > scan_idx_r);
    end
  end
  assign above_any = |above;

  // Status to the controller.
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.scan_end   = (scan_idx_r == SLOTS_C);
  assign sts.scan_live  = !sts.scan_end && live_r[scan_idx_r[IW-1:0]];
  assign sts.scan_found = found_r;

  // Operation logic: executes the latched command or one scan step.
  always_comb begin
    live_nxt       = live_r;
    free_depth_nxt = free_depth_r;
    next_fresh_nxt = next_fresh_r;
    live_total_nxt = live_total_r;
    scan_idx_nxt   = scan_idx_r;
    found_nxt      = found_r;
    alloc_we       = 1'b0;
    alloc_idx      = '0;
    stack_we       = 1'b0;
    load           = 1'b0;
    res            = '0;
    res.status     = htir_pkg::STS_OK;
    res.last       = 1'b1;

    if (ctl.exec) begin
      load = 1'b1;
      case (htir_pkg::htir_cmd_t'(cmd_r))
        htir_pkg::CMD_ALLOC: begin
          if (free_depth_r != '0) begin
            alloc_idx      = stack_q_r[IW-1:0];
            free_depth_nxt = depth_m1;
            alloc_we       = 1'b1;
          end else if (next_fresh_r < SLOTS_C) begin
            alloc_idx      = next_fresh_r[IW-1:0];
            next_fresh_nxt = next_fresh_r + CW'(1);
            alloc_we       = 1'b1;
          end else begin
            res.status = htir_pkg::STS_FULL;
          end
          if (alloc_we) begin
            live_nxt[alloc_idx] = 1'b1;
            live_total_nxt      = live_total_r + htir_pkg::LIVE_W'(1);
            res.handle_out      = HW'(alloc_idx);
          end
        end
        htir_pkg::CMD_FREE: begin
          res.handle_out = handle_r;
          if (handle_ok && (free_depth_r < SLOTS_C)) begin
            live_nxt[handle_r[IW-1:0]] = 1'b0;
            stack_we                   = 1'b1;
            free_depth_nxt             = free_depth_r + CW'(1);
            if (live_total_r != '0) begin
              live_total_nxt = live_total_r - htir_pkg::LIVE_W'(1);
            end
          end else begin
            res.status = htir_pkg::STS_NO_ENTRY;
          end
        end
        htir_pkg::CMD_LOOKUP: begin
          res.handle_out = handle_r;
          if (handle_ok) begin
            {res.dir_out, res.x_out, res.y_out, res.colour_out} = fields_q_r;
          end else begin
            res.status = htir_pkg::STS_NO_ENTRY;
          end
        end
        htir_pkg::CMD_CLEAR: begin
          live_nxt       = '0;
          free_depth_nxt = '0;
          next_fresh_nxt = CW'(1);
          live_total_nxt = '0;
        end
        default: begin
          load = 1'b0;
        end
      endcase
    end

    // List scan: emit a live handle, skip a dead one, or report an empty table.
    if (ctl.scan_emit) begin
      load           = 1'b1;
      res.handle_out = HW'(scan_idx_r);
      res.last       = !above_any;
      scan_idx_nxt   = scan_idx_r + CW'(1);
      found_nxt      = 1'b1;
    end
    if (ctl.scan_skip) begin
      scan_idx_nxt = scan_idx_r + CW'(1);
    end
    if (ctl.scan_empty) begin
      load       = 1'b1;
      res.status = htir_pkg::STS_LIST_EMPTY;
    end
    if (ctl.accept) begin
      scan_idx_nxt = CW'(1);
      found_nxt    = 1'b0;
    end

    res.live_count = live_total_nxt;
  end

  // Input latch and registered memory reads, taken when a transaction is accepted.
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r      <= in_cmd;
      handle_r   <= in_handle;
      fields_r   <= {in_dir, in_x, in_y, in_colour};
      fields_q_r <= fields_mem[in_handle[IW-1:0]];
      stack_q_r  <= stack_mem[depth_m1[IW-1:0]];
    end
  end

  // Memory writes.
  always_ff @(posedge clk) begin
    if (alloc_we) begin
      fields_mem[alloc_idx] <= fields_r;
    end
    if (stack_we) begin
      stack_mem[free_depth_r[IW-1:0]] <= handle_r;
    end
  end

  // Table state and scan control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r       <= '0;
      free_depth_r <= '0;
      next_fresh_r <= CW'(1);
      live_total_r <= '0;
      scan_idx_r   <= CW'(1);
      found_r      <= 1'b0;
    end else begin
      live_r       <= live_nxt;
      free_depth_r <= free_depth_nxt;
      next_fresh_r <= next_fresh_nxt;
      live_total_r <= live_total_nxt;
      scan_idx_r   <= scan_idx_nxt;
      found_r      <= found_nxt;
    end
  end

  // Result register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_q_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_q_r;

  // Every handle ever issued is either live or on the free stack.
  `HTIR_ASSERT_NOW(a_handle_conservation, 1'b1,
    (8'(free_depth_r) + 8'(live_total_r) + 8'd1) == 8'(next_fresh_r),
    "issued handles are neither live nor free")
  // The live counter matches the live bits.
  `HTIR_ASSERT_NOW(a_live_count_match, 1'b1,
    $countones(live_r) == int'(live_total_r), "live counter disagrees with live bits")
  // The reserved handle is never live.
  `HTIR_ASSERT_NOW(a_reserved_handle, 1'b1, !live_r[0], "reserved handle became live")
  // A new result is never loaded over one that the receiver has not taken.
  `HTIR_ASSERT_NOW(a_no_overwrite, load, sts.out_free, "result register overwritten")

endmodule

`default_nettype wire

>>> hw/rtl/htir_ctrl.sv
// Controller state machine of the handle table: sequences accept, execute and list scan.
// Depends on htir_pkg and the assertion header.
`default_nettype none

`include "handle_table_with_id_recycling_unit_assert.svh"

module htir_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic [htir_pkg::CMD_W-1:0] in_cmd,
  output      logic                       in_ready,
  input  wire htir_pkg::htir_sts_t        sts,
  output      htir_pkg::htir_ctl_t        ctl
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_LIST = 3'b100
  } htir_state_t;

  htir_state_t state_r, state_nxt;

  // Next-state and command decode.
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.accept = 1'b1;
          case (htir_pkg::htir_cmd_t'(in_cmd))
            htir_pkg::CMD_ALLOC,
            htir_pkg::CMD_FREE,
            htir_pkg::CMD_LOOKUP,
            htir_pkg::CMD_CLEAR: state_nxt = ST_EXEC;
            htir_pkg::CMD_LIST:  state_nxt = ST_LIST;
            default:             state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_EXEC: begin
        if (sts.out_free) begin
          ctl.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_LIST: begin
        if (sts.scan_end) begin
          if (sts.scan_found) begin
            state_nxt = ST_IDLE;
          end else if (sts.out_free) begin
            ctl.scan_empty = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else if (sts.scan_live) begin
          ctl.scan_emit = sts.out_free;
        end else begin
          ctl.scan_skip = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // An accepted list command starts the scan.
  `HTIR_ASSERT_NEXT(a_list_starts_scan,
    in_valid && in_ready && (in_cmd == htir_pkg::CMD_LIST), state_r == ST_LIST,
    "list command did not start a scan")
  // The scan does not end before the last slot has been visited.
  `HTIR_ASSERT_NEXT(a_scan_runs_to_end, (state_r == ST_LIST) && !sts.scan_end,
    state_r == ST_LIST, "list scan left early")

endmodule

`default_nettype wire
